// ----- rtl/assert_macros.svh -----
// assertion macros shared by the crc16 frame check rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- rtl/crc16fcg_pkg.sv -----
// package for the crc16 frame check and generate unit
// shared types and crc constants, no dependencies
`default_nettype none

package crc16fcg_pkg;

   localparam logic [15:0] KERMIT_POLY = 16'h8408;
   localparam logic [15:0] KERMIT_INIT = 16'h0000;
   localparam logic [15:0] MODBUS_POLY = 16'hA001;
   localparam logic [15:0] MODBUS_INIT = 16'hFFFF;

   localparam logic VARIANT_KERMIT = 1'b0;
   localparam logic VARIANT_MODBUS = 1'b1;
   localparam logic MODE_VERIFY    = 1'b0;
   localparam logic MODE_GENERATE  = 1'b1;

   localparam logic [0:0] REG_CRC_VARIANT    = 1'b0;
   localparam logic [0:0] REG_OPERATION_MODE = 1'b1;

   localparam logic [1:0] FILL_FULL = 2'd2;

   typedef struct packed {
      logic crc_variant;
      logic operation_mode;
   } cfg_type;

   typedef struct packed {
      logic        short_frame;
      logic        crc_match;
      logic [15:0] received_crc;
      logic [15:0] crc_value;
   } result_type;

endpackage

`default_nettype wire

// ----- rtl/crc16_frame_check_generate_unit.sv -----
// top level of the crc16 frame check and generate unit
// depends on crc16fcg_pkg and crc16fcg_frame_core
// The unit takes one frame byte per cycle on the req stream while no final byte
// waits (tlast marks the final byte) and runs a reflected CRC-16, KERMIT or
// MODBUS per csr register 0, either verifying the two trailing CRC bytes or
// generating over the whole frame per csr register 1. Each byte passes an input
// register and then an eight-bit CRC update into the frame state, so the
// sustained rate is one byte per clock; the final byte of a frame also loads
// the rsp register after the input register, which then shows the frame result.
// A pending result does not block the next bytes of a new frame; only a second
// final byte waits while the previous result is not yet taken. Write the csr
// registers only while no frame is in flight.
`default_nettype none

module crc16_frame_check_generate_unit
   import crc16fcg_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // data_byte[7:0]
   input  wire logic        req_tlast,   // last_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [31:0] rsp_tdata,   // crc_value[15:0], received_crc[31:16]
   output logic      [1:0]  rsp_tuser,   // crc_match[0], short_frame[1]
   input  wire logic        csr_we,
   input  wire logic [0:0]  csr_index,
   input  wire logic [0:0]  csr_wdata
);

   cfg_type     cfg_ff;
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_data_ff;
   logic        in_last_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_data_ff;
   result_type  result;
   logic        step;

   assign step       = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;

   always_comb begin
      priority if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      priority if (step && in_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   crc16fcg_frame_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (in_data_ff),
      .last_byte (in_last_ff),
      .cfg       (cfg_ff),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '0;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               REG_CRC_VARIANT:    cfg_ff.crc_variant    <= csr_wdata[0];
               REG_OPERATION_MODE: cfg_ff.operation_mode <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (step && in_last_ff) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_data_ff.received_crc, rsp_data_ff.crc_value};
   assign rsp_tuser  = {rsp_data_ff.short_frame, rsp_data_ff.crc_match};

endmodule

`default_nettype wire

// ----- rtl/crc16fcg_byte_update.sv -----
// eight-bit reflected crc-16 update, one byte per call
// depends on crc16fcg_pkg
`default_nettype none

module crc16fcg_byte_update
   import crc16fcg_pkg::*;
(
   input  wire logic [15:0] crc_in,
   input  wire logic [7:0]  data,
   input  wire logic        crc_variant,
   output logic      [15:0] crc_out
);

   always_comb begin
      logic [15:0] poly;
      logic [15:0] crc;
      poly = (crc_variant == VARIANT_MODBUS) ? MODBUS_POLY : KERMIT_POLY;
      crc  = crc_in ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (crc[0]) begin
            crc = (crc >> 1) ^ poly;
         end else begin
            crc = crc >> 1;
         end
      end
      crc_out = crc;
   end

endmodule

`default_nettype wire

// ----- rtl/crc16fcg_frame_core.sv -----
// frame state: running crc, two-byte delay line and result assembly
// depends on crc16fcg_pkg, crc16fcg_byte_update, assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module crc16fcg_frame_core
   import crc16fcg_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire logic [7:0] data_byte,
   input  wire logic       last_byte,
   input  wire cfg_type    cfg,
   output result_type      result
);

   logic [15:0] running_crc_ff, running_crc_in;
   logic [7:0]  held_older_ff, held_older_in;
   logic [7:0]  held_newer_ff, held_newer_in;
   logic [1:0]  fill_count_ff, fill_count_in;
   logic        frame_start_ff, frame_start_in;

   logic [15:0] init_value;
   logic [15:0] crc_base;
   logic [1:0]  fill_base;
   logic [7:0]  upd_data;
   logic [15:0] upd_crc;
   logic [15:0] rx_crc;

   assign init_value = (cfg.crc_variant == VARIANT_MODBUS) ? MODBUS_INIT : KERMIT_INIT;
   assign crc_base   = frame_start_ff ? init_value : running_crc_ff;
   assign fill_base  = frame_start_ff ? 2'd0 : fill_count_ff;
   assign upd_data   = (cfg.operation_mode == MODE_GENERATE) ? data_byte : held_older_ff;

   crc16fcg_byte_update u_update (
      .crc_in      (crc_base),
      .data        (upd_data),
      .crc_variant (cfg.crc_variant),
      .crc_out     (upd_crc)
   );

   always_comb begin
      held_older_in = held_older_ff;
      held_newer_in = held_newer_ff;
      if (cfg.operation_mode == MODE_GENERATE) begin
         running_crc_in = upd_crc;
         fill_count_in  = 2'd0;
      end else begin
         running_crc_in = (fill_base == FILL_FULL) ? upd_crc : crc_base;
         held_older_in  = held_newer_ff;
         held_newer_in  = data_byte;
         fill_count_in  = (fill_base == FILL_FULL) ? FILL_FULL : fill_base + 2'd1;
      end
      frame_start_in = last_byte;
   end

   assign rx_crc = (cfg.crc_variant == VARIANT_MODBUS) ? {held_older_in, held_newer_in}
                                                       : {held_newer_in, held_older_in};

   always_comb begin
      result.crc_value    = running_crc_in;
      result.received_crc = 16'h0000;
      result.crc_match    = 1'b0;
      result.short_frame  = 1'b0;
      if (cfg.operation_mode == MODE_VERIFY) begin
         if (fill_count_in != FILL_FULL) begin
            result.short_frame = 1'b1;
         end else begin
            result.received_crc = rx_crc;
            result.crc_match    = (rx_crc == running_crc_in);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_crc_ff <= KERMIT_INIT;
         held_older_ff  <= 8'h00;
         held_newer_ff  <= 8'h00;
         fill_count_ff  <= 2'd0;
         frame_start_ff <= 1'b1;
      end else if (step) begin
         running_crc_ff <= running_crc_in;
         held_older_ff  <= held_older_in;
         held_newer_ff  <= held_newer_in;
         fill_count_ff  <= fill_count_in;
         frame_start_ff <= frame_start_in;
      end
   end

   `ASSERT_ALWAYS(a_fill_bounded, clock, reset, fill_count_ff != 2'd3)
   `ASSERT_NEXT(a_last_opens_frame, clock, reset, step && last_byte, frame_start_ff)
   `ASSERT_NEXT(a_generate_clears_fill, clock, reset,
                step && (cfg.operation_mode == MODE_GENERATE), fill_count_ff == 2'd0)

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// testbench for crc16_frame_check_generate_unit: kermit and modbus crc, verify and generate
// streams byte frames through the req port and checks each frame result on the rsp port
// depends on crc16fcg_pkg and the unit rtl
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import crc16fcg_pkg::*;

   localparam int CLOCK_PERIOD   = 10;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int CSR_SETTLE     = 4;
   localparam int END_DRAIN      = 8;
   localparam int PHASE_ITEMS    = 132;
   localparam int RANDOM_PHASES  = 12;
   localparam int REPORT_CAP     = 40;

   typedef logic [7:0] byte_vec_type[$];

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } frame_byte_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_we     = 1'b0;
   logic [0:0]  csr_index  = '0;
   logic [0:0]  csr_wdata  = '0;

   crc16_frame_check_generate_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // stimulus and expected frame results
   frame_byte_type byte_q[$];
   result_type     frame_result_q[$];

   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;
   int items_queued   = 0;
   int quiet_cycles   = 0;
   int error_count    = 0;
   int bytes_in       = 0;
   int frames_checked = 0;
   int matches_seen   = 0;
   int shorts_seen    = 0;
   bit req_fire       = 1'b0;

   // configuration copy and frame state of the predictor
   logic        cfg_variant   = VARIANT_KERMIT;
   logic        cfg_mode      = MODE_VERIFY;
   logic [15:0] sum_crc       = KERMIT_INIT;
   logic [7:0]  tail_old      = '0;
   logic [7:0]  tail_new      = '0;
   logic [1:0]  tail_cnt      = '0;
   logic        at_frame_head = 1'b1;

   function automatic logic [15:0] crc_seed(input logic v);
      return (v == VARIANT_MODBUS) ? MODBUS_INIT : KERMIT_INIT;
   endfunction

   function automatic logic [15:0] crc16_reflect_byte(input logic v, input logic [15:0] c,
                                                      input logic [7:0] d);
      logic [15:0] poly;
      logic [15:0] r;
      poly = (v == VARIANT_MODBUS) ? MODBUS_POLY : KERMIT_POLY;
      r = c ^ {8'h00, d};
      for (int k = 0; k < 8; k++)
         r = r[0] ? ((r >> 1) ^ poly) : (r >> 1);
      return r;
   endfunction

   task automatic absorb_byte(input logic [7:0] d, input logic last, output logic emit,
                              output result_type res);
      logic [15:0] rx;
      if (at_frame_head) begin
         sum_crc = crc_seed(cfg_variant);
         tail_cnt = '0;
         at_frame_head = 1'b0;
      end
      if (cfg_mode == MODE_GENERATE) begin
         sum_crc = crc16_reflect_byte(cfg_variant, sum_crc, d);
         tail_cnt = '0;
      end else begin
         if (tail_cnt == FILL_FULL)
            sum_crc = crc16_reflect_byte(cfg_variant, sum_crc, tail_old);
         tail_old = tail_new;
         tail_new = d;
         if (tail_cnt != FILL_FULL)
            tail_cnt = tail_cnt + 2'd1;
      end
      emit = last;
      res = '0;
      if (last) begin
         at_frame_head = 1'b1;
         res.crc_value = sum_crc;
         if (cfg_mode == MODE_VERIFY) begin
            if (tail_cnt != FILL_FULL) begin
               res.short_frame = 1'b1;
            end else begin
               rx = (cfg_variant == VARIANT_MODBUS) ? {tail_old, tail_new} : {tail_new, tail_old};
               res.received_crc = rx;
               res.crc_match = (rx == sum_crc);
            end
         end
      end
   endtask

   task automatic check_field(input string what, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         error_count++;
         if (error_count <= REPORT_CAP)
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      end
   endtask

   // driver: new byte or idle, and a random rsp_tready, at the falling edge
   always @(negedge clock) begin
      frame_byte_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (!req_tvalid || req_fire) begin
            if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = byte_q.pop_front();
               req_tdata  <= nxt.data;
               req_tlast  <= nxt.last;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // monitor: predict on each accepted byte, check each accepted result
   always @(posedge clock) begin
      logic       emit;
      logic       rsp_fire;
      result_type want;
      result_type got;
      req_fire = req_tvalid && req_tready;
      rsp_fire = rsp_tvalid && rsp_tready;
      if (!reset) begin
         if (req_fire) begin
            bytes_in++;
            absorb_byte(req_tdata, req_tlast, emit, want);
            if (emit)
               frame_result_q.push_back(want);
         end
         if (rsp_fire) begin
            got = {rsp_tuser, rsp_tdata};
            if (frame_result_q.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_CAP)
                  $display("%0t: unexpected result, expected none, actual %h", $time, got);
            end else begin
               want = frame_result_q.pop_front();
               check_field("crc_value", want.crc_value, got.crc_value);
               check_field("received_crc", want.received_crc, got.received_crc);
               check_field("crc_match", 16'(want.crc_match), 16'(got.crc_match));
               check_field("short_frame", 16'(want.short_frame), 16'(got.short_frame));
               frames_checked++;
               if (want.crc_match)
                  matches_seen++;
               if (want.short_frame)
                  shorts_seen++;
            end
         end
         if (req_fire || rsp_fire)
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
   end

   task automatic program_csr(input logic v, input logic m);
      repeat (CSR_SETTLE) @(posedge clock);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= REG_CRC_VARIANT;
      csr_wdata <= v;
      @(negedge clock);
      csr_index <= REG_OPERATION_MODE;
      csr_wdata <= m;
      @(negedge clock);
      csr_we <= 1'b0;
      cfg_variant = v;
      cfg_mode = m;
      @(posedge clock);
   endtask

   task automatic drain_phase();
      while (byte_q.size() != 0 || req_tvalid || frame_result_q.size() != 0)
         @(posedge clock);
   endtask

   // seal appends the crc in the byte order of the variant, spoil flips one bit
   task automatic send_frame(input byte_vec_type body, input bit seal, input bit spoil);
      logic [15:0] c;
      int k;
      if (seal) begin
         c = crc_seed(cfg_variant);
         foreach (body[i])
            c = crc16_reflect_byte(cfg_variant, c, body[i]);
         if (cfg_variant == VARIANT_MODBUS) begin
            body.push_back(c[15:8]);
            body.push_back(c[7:0]);
         end else begin
            body.push_back(c[7:0]);
            body.push_back(c[15:8]);
         end
      end
      if (spoil) begin
         k = $urandom_range(body.size() - 1);
         body[k] = body[k] ^ (8'h01 << $urandom_range(7));
      end
      foreach (body[i]) begin
         byte_q.push_back('{data: body[i], last: (i == body.size() - 1)});
         items_queued++;
      end
   endtask

   task automatic add_random_frame();
      byte_vec_type body;
      int pick;
      int n;
      bit seal;
      bit spoil;
      pick = $urandom_range(99);
      seal = 1'b0;
      spoil = 1'b0;
      if (cfg_mode == MODE_GENERATE)
         n = (pick < 8) ? $urandom_range(40, 17) : $urandom_range(12, 1);
      else if (pick < 12)
         n = 1;
      else if (pick < 30)
         n = $urandom_range(12, 2);
      else begin
         n = (pick >= 95) ? $urandom_range(30, 11) : $urandom_range(10, 0);
         seal = 1'b1;
         spoil = (pick < 38);
      end
      for (int i = 0; i < n; i++)
         body.push_back(8'($urandom_range(255)));
      send_frame(body, seal, spoil);
   endtask

   initial begin
      int target;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed frames: short, bare crc, matching and broken trailers, generate
      send_idle_pct = 38;
      recv_idle_pct = 55;
      program_csr(VARIANT_KERMIT, MODE_VERIFY);
      send_frame('{8'h00}, 1'b0, 1'b0);
      send_frame('{8'hFF, 8'hFF}, 1'b0, 1'b0);
      send_frame('{8'h31, 8'h32, 8'h33}, 1'b1, 1'b0);
      drain_phase();
      program_csr(VARIANT_MODBUS, MODE_VERIFY);
      send_frame('{8'hA5}, 1'b0, 1'b0);
      send_frame('{8'h01, 8'h02}, 1'b1, 1'b0);
      send_frame('{8'h00, 8'h00, 8'hFF}, 1'b0, 1'b0);
      drain_phase();
      program_csr(VARIANT_KERMIT, MODE_GENERATE);
      send_frame('{8'hFF}, 1'b0, 1'b0);
      send_frame('{8'h00, 8'h80}, 1'b0, 1'b0);
      drain_phase();
      program_csr(VARIANT_MODBUS, MODE_GENERATE);
      send_frame('{8'h00}, 1'b0, 1'b0);
      send_frame('{8'hFF, 8'h7F, 8'h01}, 1'b0, 1'b0);
      drain_phase();

      // random frames, every setting under each idling profile
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p / 4)
            0: begin
               send_idle_pct = 38;
               recv_idle_pct = 55;
            end
            1: begin
               send_idle_pct = 55;
               recv_idle_pct = 38;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         program_csr(p[0], p[1]);
         target = items_queued + PHASE_ITEMS;
         while (items_queued < target)
            add_random_frame();
         drain_phase();
      end

      repeat (END_DRAIN) @(posedge clock);
      if (frame_result_q.size() != 0) begin
         error_count++;
         $display("%0t: %0d frame results never arrived", $time, frame_result_q.size());
      end
      $display("covered %0d bytes in %0d frames, kermit and modbus in verify and generate",
               bytes_in, frames_checked);
      $display("%0d matching trailers, %0d short verify frames, %0d mismatches",
               matches_seen, shorts_seen, error_count);
      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
   end

endmodule

`default_nettype wire
